// ===== sv/bf3_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the 3x3 clipped box filter.
package bf3_pkg;

  localparam int MAX_SIZE_DEF     = 1024;
  localparam int CHANNEL_BITS_DEF = 16;

  localparam int SIZE_W      = 11;  // image_size register
  localparam int CH_IO_W     = 16;  // channel field width on the ports
  localparam int COORD_OUT_W = 10;  // out_row / out_col
  localparam int S_TDATA_W   = 3 * CH_IO_W;
  localparam int M_TDATA_W   = 72;  // 68 bits of fields, padded to bytes
  localparam int M_FIELD_W   = 2 * COORD_OUT_W + 3 * CH_IO_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

  // divisor of the clipped neighbourhood
  typedef enum logic [1:0] {
    DIV_4,
    DIV_6,
    DIV_9
  } div_t;

  typedef struct packed {
    logic                   last;
    div_t                   div;
    logic [COORD_OUT_W-1:0] row;
    logic [COORD_OUT_W-1:0] col;
  } res_tag_t;

endpackage

// ===== sv/box_filter_3x3_edge_clipped.sv =====
`timescale 1ns / 1ps
// 3x3 clipped box filter over a square RGB raster stream.
// A completing pixel passes stage 1, window, mean-stage and output registers to m_tvalid.
// Throughput: one pixel per cycle while m_tready is high; a last-column or bottom-row
//   pixel gives up to four beats, one per cycle via the single mean unit; input stalls.
// Reset (rst, synchronous): counters, pipeline valids cleared, size back to 32; the row
//   memory is not cleared, no clearing pass.
module box_filter_3x3_edge_clipped #(
  parameter int MAX_SIZE     = bf3_pkg::MAX_SIZE_DEF,
  parameter int CHANNEL_BITS = bf3_pkg::CHANNEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bf3_pkg::SIZE_W-1:0]        cfg_wdata,   // image_size
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bf3_pkg::S_TDATA_W-1:0]     s_tdata,     // red_in, green_in, blue_in
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bf3_pkg::M_TDATA_W-1:0]     m_tdata,     // out_row, out_col, red_out,
                                                         // green_out, blue_out, zero pad
  output logic                              m_tlast      // run_last
);
  import bf3_pkg::*;

  localparam int CW    = $clog2(MAX_SIZE);
  localparam int NW    = $clog2(MAX_SIZE + 1);
  localparam int PIX_W = 3 * CHANNEL_BITS;
  localparam int SUM_W = CHANNEL_BITS + 4;

  logic [SIZE_W-1:0] image_size;
  logic [NW-1:0]     n_m1;
  logic [CW-1:0]     row_count;
  logic [CW-1:0]     col_count;
  logic              last_col;
  logic              last_row;
  logic              in_acc;

  // stage 1: pixel waits here for its row-memory read
  logic              s1_valid;
  logic [PIX_W-1:0]  s1_pix;
  logic [CW-1:0]     s1_row;
  logic [CW-1:0]     s1_col;
  logic              s1_last_col;
  logic              s1_last_row;
  logic              s1_adv;
  logic              win_ready;
  logic [2*PIX_W-1:0] rd_data;     // {newer, older}
  logic [PIX_W-1:0]  col_top;
  logic [PIX_W-1:0]  col_mid;
  logic [PIX_W-1:0]  in_pix;

  logic              res_valid;
  logic              res_ready;
  logic [3*SUM_W-1:0] res_sum;
  res_tag_t          res_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= SIZE_RESET;
    end else if (cfg_we) begin
      image_size <= cfg_wdata;
    end
  end

  // size clamped to 2..MAX_SIZE, minus one
  always_comb begin
    if (image_size < SIZE_W'(2)) begin
      n_m1 = NW'(1);
    end else if (32'(image_size) > MAX_SIZE) begin
      n_m1 = NW'(MAX_SIZE - 1);
    end else begin
      n_m1 = NW'(image_size) - NW'(1);
    end
  end

  assign last_col = NW'(col_count) >= n_m1;
  assign last_row = NW'(row_count) >= n_m1;
  assign in_acc   = s_tvalid && s_tready;
  assign s1_adv   = s1_valid && win_ready;
  assign s_tready = !s1_valid || win_ready;

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign in_pix[k*CHANNEL_BITS +: CHANNEL_BITS] =
      s_tdata[k*CH_IO_W +: CHANNEL_BITS];
  end

  // raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + CW'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix      <= in_pix;
      s1_row      <= row_count;
      s1_col      <= col_count;
      s1_last_col <= last_col;
      s1_last_row <= last_row;
    end
  end

  // Read at accept, write back as the pixel leaves stage 1. Successive pixels
  // always hit different columns, and the next visit to a column is read only
  // after its write, so no forwarding is needed.
  bf3_line_mem #(
    .DEPTH (MAX_SIZE),
    .WIDTH (2 * PIX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_count),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data ({s1_pix, rd_data[2*PIX_W-1:PIX_W]})
  );

  // rows above the image read as zero
  assign col_top = (s1_row >= CW'(2)) ? rd_data[PIX_W-1:0] : '0;
  assign col_mid = (s1_row != '0) ? rd_data[2*PIX_W-1:PIX_W] : '0;

  bf3_window #(
    .MAX_SIZE     (MAX_SIZE),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_win (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (win_ready),
    .top       (col_top),
    .mid       (col_mid),
    .bot       (s1_pix),
    .row       (s1_row),
    .col       (s1_col),
    .last_col  (s1_last_col),
    .last_row  (s1_last_row),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_sum   (res_sum),
    .res_tag   (res_tag)
  );

  bf3_mean #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_mean (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_ready (res_ready),
    .sum      (res_sum),
    .tag      (res_tag),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== sv/bf3_line_mem.sv =====
`timescale 1ns / 1ps
// Row buffer memory: one write port, one registered read port.
module bf3_line_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 96
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/bf3_window.sv =====
`timescale 1ns / 1ps
// 3x3 window held as column sums, and the sequencer that issues up to four results.
module bf3_window #(
  parameter int MAX_SIZE     = bf3_pkg::MAX_SIZE_DEF,
  parameter int CHANNEL_BITS = bf3_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [3*CHANNEL_BITS-1:0]              top,
  input  logic [3*CHANNEL_BITS-1:0]              mid,
  input  logic [3*CHANNEL_BITS-1:0]              bot,
  input  logic [$clog2(MAX_SIZE)-1:0]            row,
  input  logic [$clog2(MAX_SIZE)-1:0]            col,
  input  logic                                   last_col,
  input  logic                                   last_row,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output logic [3*(CHANNEL_BITS+4)-1:0]          res_sum,
  output bf3_pkg::res_tag_t                      res_tag
);
  import bf3_pkg::*;

  localparam int CW    = $clog2(MAX_SIZE);
  localparam int VW    = CHANNEL_BITS + 2;
  localparam int LW    = CHANNEL_BITS + 1;
  localparam int SUM_W = CHANNEL_BITS + 4;

  // [column][channel], column 2 newest
  logic [VW-1:0] v_col [3][3];
  logic [LW-1:0] l_col [3][3];
  logic [3:0]    mask;
  logic [CW-1:0] hold_row;
  logic [CW-1:0] hold_col;
  logic          rlo_up;
  logic          clo;

  logic [1:0]    idx;
  logic [3:0]    mask_rest;
  logic          sel_rlo;
  logic          sel_clo;
  logic [CW-1:0] sel_row;
  logic [CW-1:0] sel_col;
  logic          load;

  always_comb begin
    idx = 2'd3;
    if (mask[0]) begin
      idx = 2'd0;
    end else if (mask[1]) begin
      idx = 2'd1;
    end else if (mask[2]) begin
      idx = 2'd2;
    end
    mask_rest      = mask;
    mask_rest[idx] = 1'b0;
  end

  assign res_valid = mask != 4'd0;
  assign in_ready  = !res_valid || (res_ready && mask_rest == 4'd0);
  assign load      = in_valid && in_ready;

  always_comb begin
    case (idx)
      2'd0: begin
        sel_rlo = rlo_up;
        sel_clo = clo;
        sel_row = hold_row - CW'(1);
        sel_col = hold_col - CW'(1);
      end
      2'd1: begin
        sel_rlo = rlo_up;
        sel_clo = 1'b1;
        sel_row = hold_row - CW'(1);
        sel_col = hold_col;
      end
      2'd2: begin
        sel_rlo = 1'b1;
        sel_clo = clo;
        sel_row = hold_row;
        sel_col = hold_col - CW'(1);
      end
      default: begin
        sel_rlo = 1'b1;
        sel_clo = 1'b1;
        sel_row = hold_row;
        sel_col = hold_col;
      end
    endcase
  end

  always_comb begin
    logic [SUM_W-1:0] s;
    for (int k = 0; k < 3; k++) begin
      s = '0;
      for (int c = 0; c < 3; c++) begin
        if (c != 0 || !sel_clo) begin
          s = s + (sel_rlo ? SUM_W'(l_col[c][k]) : SUM_W'(v_col[c][k]));
        end
      end
      res_sum[k*SUM_W +: SUM_W] = s;
    end
    res_tag.last = mask_rest == 4'd0;
    res_tag.row  = COORD_OUT_W'(sel_row);
    res_tag.col  = COORD_OUT_W'(sel_col);
    if (sel_rlo && sel_clo) begin
      res_tag.div = DIV_4;
    end else if (sel_rlo || sel_clo) begin
      res_tag.div = DIV_6;
    end else begin
      res_tag.div = DIV_9;
    end
  end

  // window payload: shifts one column per pixel
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < 3; k++) begin
        v_col[0][k] <= v_col[1][k];
        v_col[1][k] <= v_col[2][k];
        l_col[0][k] <= l_col[1][k];
        l_col[1][k] <= l_col[2][k];
        l_col[2][k] <= LW'(mid[k*CHANNEL_BITS +: CHANNEL_BITS])
                     + LW'(bot[k*CHANNEL_BITS +: CHANNEL_BITS]);
        v_col[2][k] <= VW'(top[k*CHANNEL_BITS +: CHANNEL_BITS])
                     + VW'(mid[k*CHANNEL_BITS +: CHANNEL_BITS])
                     + VW'(bot[k*CHANNEL_BITS +: CHANNEL_BITS]);
      end
      hold_row <= row;
      hold_col <= col;
      rlo_up   <= row < CW'(2);
      clo      <= col < CW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 4'd0;
    end else if (load) begin
      mask <= {last_row && last_col,
               last_row && col != '0,
               row != '0 && last_col,
               row != '0 && col != '0};
    end else if (res_valid && res_ready) begin
      mask <= mask_rest;
    end
  end

endmodule

// ===== sv/bf3_mean.sv =====
`timescale 1ns / 1ps
// Mean by reciprocal multiply (a shift for the divide by four), and the output register.
module bf3_mean #(
  parameter int CHANNEL_BITS = bf3_pkg::CHANNEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [3*(CHANNEL_BITS+4)-1:0]     sum,
  input  bf3_pkg::res_tag_t                 tag,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bf3_pkg::M_TDATA_W-1:0]     m_tdata,
  output logic                              m_tlast
);
  import bf3_pkg::*;

  localparam int SUM_W = CHANNEL_BITS + 4;
  localparam int SHIFT = SUM_W + 4;
  localparam int M_W   = SHIFT - 2;
  localparam logic [M_W-1:0] M6 = M_W'(((1 << SHIFT) + 5) / 6);
  localparam logic [M_W-1:0] M9 = M_W'(((1 << SHIFT) + 8) / 9);

  logic                   s3_valid;
  logic [3*SUM_W-1:0]     s3_sum;
  res_tag_t               s3_tag;
  logic                   out_free;
  logic                   s3_adv;
  logic [3*CH_IO_W-1:0]   mean;

  assign out_free = !m_tvalid || m_tready;
  assign s3_adv   = s3_valid && out_free;
  assign in_ready = !s3_valid || out_free;

  always_comb begin
    logic [M_W-1:0]       m;
    logic [SUM_W+M_W-1:0] prod;
    logic [SUM_W-1:0]     q;
    m = (s3_tag.div == DIV_9) ? M9 : M6;
    for (int k = 0; k < 3; k++) begin
      prod = (SUM_W + M_W)'(s3_sum[k*SUM_W +: SUM_W]) * (SUM_W + M_W)'(m);
      if (s3_tag.div == DIV_4) begin
        q = s3_sum[k*SUM_W +: SUM_W] >> 2;
      end else begin
        q = SUM_W'(prod >> SHIFT);
      end
      mean[k*CH_IO_W +: CH_IO_W] = CH_IO_W'(q[CHANNEL_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (in_ready) begin
      s3_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s3_sum <= sum;
      s3_tag <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      m_tdata <= M_TDATA_W'({mean, s3_tag.col, s3_tag.row});
      m_tlast <= s3_tag.last;
    end
  end

endmodule

// ===== sv/bf3_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the box filter, bound to the top level.
module bf3_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [bf3_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tlast
);
  import bf3_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_TDATA_W-1:M_FIELD_W] == '0)
    else $error("tdata padding not zero");

endmodule

bind box_filter_3x3_edge_clipped bf3_checker u_bf3_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== tb/box_filter_3x3_edge_clipped_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the 3x3 clipped box filter: predicted means versus DUT beats.
module box_filter_3x3_edge_clipped_tb;
  import bf3_pkg::*;

  localparam int MAXSZ = MAX_SIZE_DEF;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [COORD_OUT_W-1:0] row;
    logic [COORD_OUT_W-1:0] col;
    logic [CH_IO_W-1:0]     red;
    logic [CH_IO_W-1:0]     green;
    logic [CH_IO_W-1:0]     blue;
    logic                   last;
  } smooth_px_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // red_in, green_in, blue_in
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // out_row, out_col, red, green, blue, pad
  logic m_tlast;                        // run_last

  box_filter_3x3_edge_clipped dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state: own copy of row stores, window and raster position
  logic [47:0] older_row [MAXSZ];
  logic [47:0] newer_row [MAXSZ];
  logic [47:0] win [9];
  int unsigned pos_row, pos_col;
  int unsigned size_reg = 32;

  smooth_px_t expected_px[$];
  int  mismatches = 0;
  int  beats_in = 0, beats_out = 0;
  bit  sink_stall = 1'b1;
  bit  src_idle = 1'b1;
  longint cycles = 0;

  function automatic smooth_px_t window_mean(int unsigned r, int unsigned c,
                                             int unsigned rlo, int unsigned clo);
    smooth_px_t p;
    int unsigned sr, sg, sb, cnt;
    sr = 0; sg = 0; sb = 0;
    cnt = (3 - rlo) * (3 - clo);
    for (int i = rlo; i < 3; i++)
      for (int j = clo; j < 3; j++) begin
        sr += win[i*3+j][47:32];
        sg += win[i*3+j][31:16];
        sb += win[i*3+j][15:0];
      end
    p.row = r[9:0];
    p.col = c[9:0];
    p.red = 16'(sr / cnt);
    p.green = 16'(sg / cnt);
    p.blue = 16'(sb / cnt);
    p.last = 1'b0;
    return p;
  endfunction

  // predict the beats caused by one pixel
  function automatic void predict_pixel(logic [47:0] pix);
    int unsigned n, rr, cc, rlo, clo, k;
    bit lc, lr;
    smooth_px_t res[4];
    n = size_reg;
    if (n < 2) n = 2;
    if (n > MAXSZ) n = MAXSZ;
    rr = pos_row;
    cc = pos_col;
    if (cc >= MAXSZ) cc = MAXSZ - 1;
    lc = cc >= n - 1;
    lr = rr >= n - 1;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = (rr >= 2) ? older_row[cc] : '0;
    win[5] = (rr >= 1) ? newer_row[cc] : '0;
    win[8] = pix;
    older_row[cc] = newer_row[cc];
    newer_row[cc] = pix;
    rlo = (rr >= 2) ? 0 : 1;
    clo = (cc >= 2) ? 0 : 1;
    k = 0;
    if (rr >= 1 && cc >= 1) res[k++] = window_mean(rr - 1, cc - 1, rlo, clo);
    if (rr >= 1 && lc)      res[k++] = window_mean(rr - 1, cc, rlo, 1);
    if (lr && cc >= 1)      res[k++] = window_mean(rr, cc - 1, 1, clo);
    if (lr && lc)           res[k++] = window_mean(rr, cc, 1, 1);
    if (k > 0) res[k-1].last = 1'b1;
    for (int i = 0; i < k; i++) expected_px.push_back(res[i]);
    if (lc) begin
      pos_col = 0;
      pos_row = lr ? 0 : rr + 1;
    end else begin
      pos_col = cc + 1;
    end
  endfunction

  // one pixel beat, with optional random idle burst beforehand;
  // tvalid stays high afterwards so beats can follow back to back
  task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, g, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_pixel({r, g, b});
    beats_in++;
    @(negedge clk);
  endtask

  // random stall bursts on the output side
  initial begin
    forever begin
      @(negedge clk);
      if (sink_stall && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // checker: each result beat against the oldest prediction
  always @(posedge clk) begin
    smooth_px_t got, exp_px;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      got.row = m_tdata[9:0];
      got.col = m_tdata[19:10];
      got.red = m_tdata[35:20];
      got.green = m_tdata[51:36];
      got.blue = m_tdata[67:52];
      got.last = m_tlast;
      beats_out++;
      if (expected_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        exp_px = expected_px.pop_front();
        if (got !== exp_px) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_px, got);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // idle point: source dropped, all predictions drained, then latency margin
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // new size, written only when idle; the raster position is not reset
  task automatic set_size(int unsigned n);
    cfg_we <= 1'b1;
    cfg_wdata <= SIZE_W'(n);
    @(negedge clk);
    cfg_we <= 1'b0;
    size_reg = n;
    @(negedge clk);
  endtask

  task automatic send_frame(int unsigned n, int mode);
    logic [15:0] r, g, b;
    for (int i = 0; i < n * n; i++) begin
      case (mode)
        0: begin r = 16'hFFFF; g = 16'hFFFF; b = 16'hFFFF; end
        1: begin r = '0; g = 16'hFFFF; b = (i % 2) ? 16'hFFFF : 16'h0; end
        default: begin
          r = 16'($urandom); g = 16'($urandom); b = 16'($urandom);
        end
      endcase
      send_pixel(r, g, b);
    end
  endtask

  // directed: smallest frames, all-ones (sum overflow check), out-of-range size 0
  task automatic test_directed();
    set_size(2);
    send_frame(2, 0);
    send_frame(2, 1);
    drain();
    set_size(0);            // clamps to 2
    send_frame(2, 2);
    drain();
    set_size(3);
    send_frame(3, 0);
    drain();
  endtask

  // random frames over small sizes, including the clamp case of size 1
  task automatic test_random_frames();
    int unsigned n;
    while (beats_in < 420) begin
      n = $urandom_range(1, 7);
      set_size(n);
      send_frame(n < 2 ? 2 : n, 2);
      drain();
    end
  endtask

  // largest size: register top value clamps to 1024; a few rows then finishing by
  // a large partial pass is too long, so no pixels run at full width, and a small
  // frame after reset of position is impossible.
  // Instead the top register value is written and the last part runs at 4 with no idling.
  task automatic test_extremes_no_idle();
    set_size(11'h7FF);
    set_size(4);
    src_idle = 1'b0;
    sink_stall = 1'b0;
    send_frame(4, 2);
    send_frame(4, 0);
    drain();
  endtask

  initial begin
    for (int i = 0; i < 9; i++) win[i] = '0;
    pos_row = 0;
    pos_col = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_frames();
    test_extremes_no_idle();
    $display("sent %0d pixels, checked %0d smoothed beats", beats_in, beats_out);
    $display("frames of size 2..7 with stalls, clamped sizes 0, 1 and 2047");
    if (mismatches == 0 && expected_px.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
